/* rtl/uitf_pkg.sv */
// Shared types, codes and defaults for the UART idle-timeout framer.
`timescale 1ns / 1ps

package uitf_pkg;

  // Default sizes handed to the top level
  localparam int DEF_CHANNELS  = 2;
  localparam int DEF_BUF_DEPTH = 256;

  // Fixed field widths
  localparam int FUNC_W    = 3;
  localparam int CNT_W     = 9;
  localparam int TIME_W    = 32;
  localparam int ERR_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 32;
  localparam int REG_IDX_W = 2;
  localparam int LIM_W     = 13;

  // Item selector codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BYTE    = 3'd0,
    FUNC_DMA_LEN = 3'd1,
    FUNC_POLL    = 3'd2,
    FUNC_VERDICT = 3'd3,
    FUNC_REARM   = 3'd4,
    FUNC_READ    = 3'd5
  } func_t;

  // Channel error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 3'd0,
    ERR_NO_DECODER   = 3'd1,
    ERR_NOT_FINISHED = 3'd2,
    ERR_BUSY         = 3'd3,
    ERR_OVERFLOW     = 3'd4,
    ERR_NO_BUFFER    = 3'd5
  } err_t;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_MAX_SIZE = 2'd1,
    REG_BUF_PRES = 2'd2,
    REG_DEC_PRES = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] timeout_ms;
    logic [CNT_W-1:0]  max_size;
    logic              buffer_present;
    logic              decoder_present;
  } cfg_t;

  // Per-channel state word kept in the state RAM
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last_time;
    logic              busy;
    err_t              err;
  } chan_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_range;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  soi;
    logic [TIME_W-1:0] now_ms;
    logic              accept;
  } item_t;

  typedef struct packed {
    logic              frame_ready;
    logic [CNT_W-1:0]  frame_length;
    logic [ERR_W-1:0]  error_code;
    logic              busy_res;
    logic [BYTE_W-1:0] read_data;
    logic              rearm_pulse;
  } result_t;

  // Write-back controls from the update logic
  typedef struct packed {
    logic             state_we;
    logic             byte_we;
    logic [CNT_W-1:0] byte_idx;
  } wb_ctl_t;

endpackage

/* rtl/uitf_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module uitf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/uitf_update.sv */
// Per-item state update and result formation for one channel word.
`timescale 1ns / 1ps

module uitf_update #(
  parameter int BUF_DEPTH = uitf_pkg::DEF_BUF_DEPTH
) (
  input  uitf_pkg::item_t                item,
  input  uitf_pkg::cfg_t                 cfg,
  input  uitf_pkg::chan_state_t          cur,
  input  logic [uitf_pkg::BYTE_W-1:0]    rd_byte,
  output uitf_pkg::chan_state_t          nxt,
  output uitf_pkg::wb_ctl_t              wb,
  output uitf_pkg::result_t              res
);

  localparam logic [uitf_pkg::LIM_W-1:0] BUF_LIM = uitf_pkg::LIM_W'(BUF_DEPTH);

  logic [uitf_pkg::LIM_W-1:0]  limit;
  logic [uitf_pkg::TIME_W-1:0] elapsed;
  logic                        ready;
  logic                        pulse;
  logic [uitf_pkg::BYTE_W-1:0] rdata;

  // Effective frame size limit
  assign limit = (uitf_pkg::LIM_W'(cfg.max_size) < BUF_LIM) ?
                 uitf_pkg::LIM_W'(cfg.max_size) : BUF_LIM;

  // Wrapping idle time since the last byte
  assign elapsed = item.now_ms - cur.last_time;

  // Apply the request to the channel word
  always_comb begin
    nxt   = cur;
    ready = 1'b0;
    pulse = 1'b0;
    rdata = '0;
    wb.state_we = item.in_range;
    wb.byte_we  = 1'b0;
    wb.byte_idx = cur.count;
    case (uitf_pkg::func_t'(item.func))
      uitf_pkg::FUNC_BYTE: begin
        if (cur.busy) begin
          nxt.err = uitf_pkg::ERR_BUSY;
        end else if (uitf_pkg::LIM_W'(cur.count) >= limit) begin
          nxt.err = uitf_pkg::ERR_OVERFLOW;
        end else if (!cfg.buffer_present) begin
          nxt.err = uitf_pkg::ERR_NO_BUFFER;
        end else begin
          wb.byte_we    = 1'b1;
          nxt.count     = cur.count + uitf_pkg::CNT_W'(1);
          nxt.last_time = item.now_ms;
        end
      end
      uitf_pkg::FUNC_DMA_LEN: begin
        if (cur.busy) begin
          nxt.err = uitf_pkg::ERR_BUSY;
        end else if (uitf_pkg::LIM_W'(item.soi) > limit) begin
          nxt.err = uitf_pkg::ERR_OVERFLOW;
        end else begin
          nxt.count     = item.soi;
          nxt.last_time = item.now_ms;
        end
      end
      uitf_pkg::FUNC_POLL: begin
        if ((cur.count != '0) && (elapsed > cfg.timeout_ms)) begin
          nxt.busy = 1'b1;
          if (cfg.decoder_present) begin
            ready   = 1'b1;
            nxt.err = uitf_pkg::ERR_NONE;
          end else begin
            nxt.err = uitf_pkg::ERR_NO_DECODER;
          end
        end else begin
          nxt.err = uitf_pkg::ERR_NOT_FINISHED;
        end
      end
      uitf_pkg::FUNC_VERDICT: begin
        if (!item.accept) begin
          nxt.count = '0;
          nxt.err   = uitf_pkg::ERR_NONE;
          nxt.busy  = 1'b0;
          pulse     = 1'b1;
        end
      end
      uitf_pkg::FUNC_REARM: begin
        nxt.count = '0;
        nxt.err   = uitf_pkg::ERR_NONE;
        nxt.busy  = 1'b0;
        pulse     = 1'b1;
      end
      uitf_pkg::FUNC_READ: begin
        if (cfg.buffer_present && (uitf_pkg::LIM_W'(item.soi) < BUF_LIM)) begin
          rdata = rd_byte;
        end
      end
      default: begin
      end
    endcase
    // Drop every effect of an item on a channel that does not exist
    if (!item.in_range) begin
      wb.byte_we = 1'b0;
    end
  end

  // Form the result word
  always_comb begin
    res = '0;
    if (item.in_range) begin
      res.frame_ready  = ready;
      res.frame_length = nxt.count;
      res.error_code   = nxt.err;
      res.busy_res     = nxt.busy;
      res.read_data    = rdata;
      res.rearm_pulse  = pulse;
    end
  end

endmodule

/* rtl/uart_idle_timeout_framer_core.sv */
// Top level of the UART idle-timeout framer: pipeline, RAMs and forwarding.
`timescale 1ns / 1ps
//
// Receive framer for CHANNELS serial channels. Each input word carries a
// selector (byte, DMA length, poll, verdict, rearm, buffer read) and the
// channel it refers to; each input word yields exactly one result word.
// Input and output channels use valid/stall: a word moves on a rising edge
// with valid high and stall low. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); the user must write it only while the block is
// idle, as the block itself does not enforce this. A word accepted on the
// input passes through stage 1 and then the output register.
// Throughput: one word per cycle while the receiver does not stall. The
// channel state RAM is read when a word is accepted and written back when
// that word leaves stage 1; a write to the same channel is forwarded to the
// next word, and the same holds for the frame store.
// When the receiver stalls, the result waits in the output register, one
// more word waits in stage 1, and in_stall rises only when both places are
// full.
// Reset clears the pipeline, the registers and the per-channel valid bits,
// so every channel reads as empty and idle at once; no clearing pass runs.
// The frame store is not cleared.
//
module uart_idle_timeout_framer_core #(
  parameter int CHANNELS  = uitf_pkg::DEF_CHANNELS,
  parameter int BUF_DEPTH = uitf_pkg::DEF_BUF_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [uitf_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [uitf_pkg::CFG_W-1:0]       cfg_data,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [uitf_pkg::FUNC_W-1:0]      func,
  input  logic                             channel,
  input  logic [uitf_pkg::BYTE_W-1:0]      data_byte,
  input  logic [uitf_pkg::CNT_W-1:0]       size_or_index,
  input  logic [uitf_pkg::TIME_W-1:0]      now_ms,
  input  logic                             accept,
  // Output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_ready,
  output logic [uitf_pkg::CNT_W-1:0]       frame_length,
  output logic [uitf_pkg::ERR_W-1:0]       error_code,
  output logic                             busy_res,
  output logic [uitf_pkg::BYTE_W-1:0]      read_data,
  output logic                             rearm_pulse
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BUF_N = CHANNELS * BUF_DEPTH;
  localparam int AW    = (BUF_N > 1) ? $clog2(BUF_N) : 1;
  localparam int ST_W  = $bits(uitf_pkg::chan_state_t);
  localparam logic [AW-1:0] ROW = AW'(BUF_DEPTH);

  uitf_pkg::cfg_t cfg;

  logic in_fire;
  logic s1_fire;
  logic in_range;

  logic              s1_valid;
  uitf_pkg::item_t   s1_item;
  logic [CH_W-1:0]   s1_ch;
  logic [AW-1:0]     s1_rd_addr;
  logic              s1_entry_valid;

  logic [CHANNELS-1:0] entry_valid;

  logic [CH_W-1:0]   in_ch;
  logic [AW-1:0]     in_rd_addr;
  logic [AW-1:0]     wr_addr;

  logic [ST_W-1:0]               st_rdata;
  logic [uitf_pkg::BYTE_W-1:0]   byte_rdata;

  // Forwarding of the write made at the edge of the last read
  logic                          fwd_st_valid;
  logic [CH_W-1:0]               fwd_st_ch;
  uitf_pkg::chan_state_t         fwd_st_data;
  logic                          fwd_byte_valid;
  logic [AW-1:0]                 fwd_byte_addr;
  logic [uitf_pkg::BYTE_W-1:0]   fwd_byte_data;

  uitf_pkg::chan_state_t         cur;
  uitf_pkg::chan_state_t         nxt;
  logic [uitf_pkg::BYTE_W-1:0]   rd_byte;
  uitf_pkg::wb_ctl_t             wb;
  uitf_pkg::result_t             res;
  uitf_pkg::result_t             out_res;

  logic st_we;
  logic byte_we;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (uitf_pkg::reg_idx_t'(cfg_index))
        uitf_pkg::REG_TIMEOUT:  cfg.timeout_ms      <= cfg_data;
        uitf_pkg::REG_MAX_SIZE: cfg.max_size        <= cfg_data[uitf_pkg::CNT_W-1:0];
        uitf_pkg::REG_BUF_PRES: cfg.buffer_present  <= cfg_data[0];
        uitf_pkg::REG_DEC_PRES: cfg.decoder_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: stage 1 moves into the output register when it is free
  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Read addresses for the accepted word
  assign in_range   = ({31'b0, channel} < 32'(CHANNELS));
  assign in_ch      = CH_W'(channel);
  assign in_rd_addr = AW'(in_ch) * ROW + AW'(size_or_index);

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload, valid bit and forwarding capture at the read edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.func      <= func;
      s1_item.in_range  <= in_range;
      s1_item.data_byte <= data_byte;
      s1_item.soi       <= size_or_index;
      s1_item.now_ms    <= now_ms;
      s1_item.accept    <= accept;
      s1_ch             <= in_ch;
      s1_rd_addr        <= in_rd_addr;
      s1_entry_valid    <= in_range && entry_valid[in_ch];
      fwd_st_ch         <= s1_ch;
      fwd_st_data       <= nxt;
      fwd_byte_addr     <= wr_addr;
      fwd_byte_data     <= s1_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_st_valid   <= 1'b0;
      fwd_byte_valid <= 1'b0;
    end else if (in_fire) begin
      fwd_st_valid   <= st_we;
      fwd_byte_valid <= byte_we;
    end
  end

  // Per-channel valid bits: an unwritten channel reads as reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (st_we) begin
      entry_valid[s1_ch] <= 1'b1;
    end
  end

  // Resolve current channel word and stored byte
  always_comb begin
    if (fwd_st_valid && (fwd_st_ch == s1_ch)) begin
      cur = fwd_st_data;
    end else if (s1_entry_valid) begin
      cur = uitf_pkg::chan_state_t'(st_rdata);
    end else begin
      cur = '0;
    end
  end

  assign rd_byte = (fwd_byte_valid && (fwd_byte_addr == s1_rd_addr)) ?
                   fwd_byte_data : byte_rdata;

  uitf_update #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_update (
    .item    (s1_item),
    .cfg     (cfg),
    .cur     (cur),
    .rd_byte (rd_byte),
    .nxt     (nxt),
    .wb      (wb),
    .res     (res)
  );

  // Write back on completion of stage 1
  assign st_we   = s1_fire && wb.state_we;
  assign byte_we = s1_fire && wb.byte_we;
  assign wr_addr = AW'(s1_ch) * ROW + AW'(wb.byte_idx);

  uitf_ram #(
    .WIDTH (ST_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (s1_ch),
    .wdata (ST_W'(nxt)),
    .re    (in_fire),
    .raddr (in_ch),
    .rdata (st_rdata)
  );

  uitf_ram #(
    .WIDTH (uitf_pkg::BYTE_W),
    .DEPTH (BUF_N)
  ) u_frame_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (wr_addr),
    .wdata (s1_item.data_byte),
    .re    (in_fire),
    .raddr (in_rd_addr),
    .rdata (byte_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign frame_ready  = out_res.frame_ready;
  assign frame_length = out_res.frame_length;
  assign error_code   = out_res.error_code;
  assign busy_res     = out_res.busy_res;
  assign read_data    = out_res.read_data;
  assign rearm_pulse  = out_res.rearm_pulse;

endmodule
